// ===== hdl/ifs_pkg.sv =====
package ifs_pkg;

    // item opcodes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } state_t;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    // bits above 30 never reach the output, so the sum wraps at 31 bits
    localparam int ACC_W    = 31;
    localparam int OUT_LSB  = 15;
    localparam logic [ACC_W-1:0] ROUND_BIAS = 31'h7fff;

    typedef struct packed {
        logic accept;
        logic start;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic fire;
        logic last_tap;
        logic pipe_empty;
        logic out_busy;
    } status_t;

endpackage

// ===== hdl/ifs_ram.sv =====
module ifs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 144,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ifs_ctrl.sv =====
module ifs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ifs_pkg::status_t status,
    output ifs_pkg::cmd_t    cmd
);

    ifs_pkg::state_t state_reg;
    ifs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ifs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ifs_pkg::ST_IDLE:
            begin
                if (in_valid && status.fire)
                begin
                    state_next = ifs_pkg::ST_MAC;
                end
            end
            ifs_pkg::ST_MAC:
            begin
                if (status.last_tap)
                begin
                    state_next = ifs_pkg::ST_DRAIN;
                end
            end
            ifs_pkg::ST_DRAIN:
            begin
                if (status.pipe_empty && !status.out_busy)
                begin
                    state_next = ifs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ifs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        cmd.accept   = 1'b0;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ifs_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                cmd.start  = in_valid && status.fire;
            end
            ifs_pkg::ST_MAC:
            begin
                cmd.step = 1'b1;
            end
            ifs_pkg::ST_DRAIN:
            begin
                cmd.load_out = status.pipe_empty && !status.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/ifs_dp.sv =====
module ifs_dp #(
    parameter int NUM_TAPS   = 144,
    parameter int DECIMATION = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ifs_pkg::cmd_t      cmd,
    output ifs_pkg::status_t   status,
    input  logic [1:0]         op,
    input  logic [7:0]         tap_index,
    input  logic signed [15:0] tap_value,
    input  logic signed [15:0] sample_i,
    input  logic signed [15:0] sample_q,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_i,
    output logic signed [15:0] out_q
);

    localparam int AW = $clog2(NUM_TAPS);
    localparam int FW = $clog2(NUM_TAPS + 1);
    localparam int PW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam logic [AW-1:0] LAST_ADDR  = AW'(NUM_TAPS - 1);
    localparam logic [FW-1:0] FULL_FILL  = FW'(NUM_TAPS);
    localparam logic [PW-1:0] LAST_PHASE = PW'(DECIMATION - 1);
    localparam int SW = ifs_pkg::SAMPLE_W;
    localparam int AC = ifs_pkg::ACC_W;

    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [FW-1:0] fill_reg;
    logic [PW-1:0] phase_reg;
    logic [AW-1:0] tap_cnt_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          s1_valid_reg;
    logic          s1_mask_reg;
    logic          s2_valid_reg;
    logic          out_valid_reg;

    logic signed [ifs_pkg::PROD_W-1:0] prod_i_reg;
    logic signed [ifs_pkg::PROD_W-1:0] prod_q_reg;
    logic [AC-1:0] acc_i_reg;
    logic [AC-1:0] acc_q_reg;
    logic signed [15:0] out_i_reg;
    logic signed [15:0] out_q_reg;

    logic          is_load;
    logic          is_push;
    logic          is_clear;
    logic          coef_wr;
    logic [15:0]   coef_rd;
    logic [2*SW-1:0] hist_rd;
    logic signed [SW-1:0] hist_i;
    logic signed [SW-1:0] hist_q;

    assign is_load  = cmd.accept && (op == ifs_pkg::OP_LOAD);
    assign is_push  = cmd.accept && (op == ifs_pkg::OP_PUSH);
    assign is_clear = cmd.accept && (op == ifs_pkg::OP_CLEAR);
    assign coef_wr  = is_load && (int'(tap_index) < NUM_TAPS);
    assign wp_next  = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;

    ifs_ram #(
        .WIDTH (ifs_pkg::COEF_W),
        .DEPTH (NUM_TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr),
        .wr_addr (AW'(tap_index)),
        .wr_data (tap_value),
        .rd_en   (cmd.step),
        .rd_addr (LAST_ADDR - tap_cnt_reg),
        .rd_data (coef_rd)
    );

    // i and q share one line, i in the upper half
    ifs_ram #(
        .WIDTH (2 * SW),
        .DEPTH (NUM_TAPS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (is_push),
        .wr_addr (wp_reg),
        .wr_data ({sample_i, sample_q}),
        .rd_en   (cmd.step),
        .rd_addr (rd_idx_reg),
        .rd_data (hist_rd)
    );

    // slots not written since the last clear read as zero
    assign hist_i = s1_mask_reg ? $signed(hist_rd[2*SW-1:SW]) : '0;
    assign hist_q = s1_mask_reg ? $signed(hist_rd[SW-1:0]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            tap_cnt_reg   <= '0;
            rd_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (is_clear)
            begin
                wp_reg    <= '0;
                fill_reg  <= '0;
                phase_reg <= '0;
            end
            else if (is_push)
            begin
                wp_reg <= wp_next;
                if (fill_reg != FULL_FILL)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                phase_reg <= (phase_reg == LAST_PHASE) ? '0 : phase_reg + 1'b1;
            end

            // oldest sample sits at the slot the next push will fill
            if (cmd.start)
            begin
                tap_cnt_reg <= '0;
                rd_idx_reg  <= wp_next;
            end
            else if (cmd.step)
            begin
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
                rd_idx_reg  <= (rd_idx_reg == LAST_ADDR) ? '0 : rd_idx_reg + 1'b1;
            end

            s1_valid_reg <= cmd.step;
            s2_valid_reg <= s1_valid_reg;

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mask_reg <= FW'(rd_idx_reg) < fill_reg;
        prod_i_reg  <= $signed(coef_rd) * hist_i;
        prod_q_reg  <= $signed(coef_rd) * hist_q;
        if (cmd.start)
        begin
            acc_i_reg <= ifs_pkg::ROUND_BIAS;
            acc_q_reg <= ifs_pkg::ROUND_BIAS;
        end
        else if (s2_valid_reg)
        begin
            acc_i_reg <= acc_i_reg + prod_i_reg[AC-1:0];
            acc_q_reg <= acc_q_reg + prod_q_reg[AC-1:0];
        end
        if (cmd.load_out)
        begin
            out_i_reg <= $signed(acc_i_reg[AC-1:ifs_pkg::OUT_LSB]);
            out_q_reg <= $signed(acc_q_reg[AC-1:ifs_pkg::OUT_LSB]);
        end
    end

    assign status.fire       = (op == ifs_pkg::OP_PUSH) && (phase_reg == LAST_PHASE);
    assign status.last_tap   = tap_cnt_reg == LAST_ADDR;
    assign status.pipe_empty = !s1_valid_reg && !s2_valid_reg;
    assign status.out_busy   = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

    // until the line is full the write slot tracks the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != FULL_FILL) |-> (FW'(wp_reg) == fill_reg))
    else $error("write position out of step with fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!s1_valid_reg && !s2_valid_reg && !cmd.step))
    else $error("result taken before the sum is complete");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (tap_cnt_reg == '0) && cmd.step)
    else $error("tap sweep did not start at the first tap");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.last_tap) |=> !cmd.step)
    else $error("tap sweep ran past the last tap");

endmodule

// ===== hdl/iq_decimating_fir_stream_top.sv =====
// Decimating Q15 FIR for complex I/Q. One coefficient set (op 0) filters both
// rails; op 1 pushes a sample pair, op 2 clears history, write slot and phase
// but keeps the taps. Other beats are taken without a stall; the push on every
// DECIMATION-th sample keeps the input stalled while one multiplier per rail
// sweeps the tap and history memories one tap per cycle (read, multiply,
// accumulate), and longer while an earlier result still waits in the output
// register. Output is bits 30..15 of 0x7fff plus the sum, wrapped. A finished
// result waits in the output register while further beats are accepted. Load
// all taps before pushing.
module iq_decimating_fir_stream_top #(
    parameter int NUM_TAPS   = 144,
    parameter int DECIMATION = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [7:0]         tap_index,
    input  logic signed [15:0] tap_value,
    input  logic signed [15:0] sample_i,
    input  logic signed [15:0] sample_q,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_i,
    output logic signed [15:0] out_q
);

    ifs_pkg::cmd_t    cmd;
    ifs_pkg::status_t status;

    ifs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ifs_dp #(
        .NUM_TAPS   (NUM_TAPS),
        .DECIMATION (DECIMATION)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (op),
        .tap_index (tap_index),
        .tap_value (tap_value),
        .sample_i  (sample_i),
        .sample_q  (sample_q),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_i     (out_i),
        .out_q     (out_q)
    );

endmodule
